// File: design/xts_pkg.sv
// ============================================================================
// xts_pkg
// Shared types, constants and scanner tables for the xml token scanner.
// ============================================================================
`default_nettype none

package xts_pkg;

    // buffer sizes
    localparam int TOKEN_CAP   = 32;
    localparam int ESCAPE_CAP  = 8;
    localparam int TOK_LW      = $clog2(TOKEN_CAP + 1);
    localparam int TOK_AW      = $clog2(TOKEN_CAP);
    localparam int ESC_LW      = $clog2(ESCAPE_CAP + 1);
    localparam int ESC_AW      = $clog2(ESCAPE_CAP);

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // table passes per word, back-up included
    localparam int MAX_PASS    = 3;

    localparam int NUM_STATES  = 11;
    localparam int NUM_CLASSES = 10;

    // action mask bits
    localparam logic [15:0] F_EOF = 16'h0001;
    localparam logic [15:0] F_LT  = 16'h0002;
    localparam logic [15:0] F_LTS = 16'h0004;
    localparam logic [15:0] F_GT  = 16'h0008;
    localparam logic [15:0] F_SGT = 16'h0010;
    localparam logic [15:0] F_EQ  = 16'h0020;
    localparam logic [15:0] F_STR = 16'h0040;
    localparam logic [15:0] F_QST = 16'h0080;
    localparam logic [15:0] F_WD  = 16'h0100;
    localparam logic [15:0] F_SVE = 16'h0200;
    localparam logic [15:0] F_ESC = 16'h0400;
    localparam logic [15:0] F_SVW = 16'h0800;
    localparam logic [15:0] F_APW = 16'h1000;
    localparam logic [15:0] F_AP  = 16'h2000;
    localparam logic [15:0] F_ER1 = 16'h4000;
    localparam logic [15:0] F_BK  = 16'h8000;
    localparam logic [15:0] F_APPW = F_APW | F_AP;

    typedef enum logic [3:0] {
        K_EOF, K_LT, K_LTS, K_GT, K_SGT, K_EQ, K_TEXT, K_QUOTED, K_WORD, K_BAD
    } t_kind;

    typedef enum logic [3:0] {
        Q_INIT, Q_OPEN, Q_OPEN2, Q_NAME, Q_NAME2, Q_QUOTE, Q_TEXT, Q_TEXTW,
        Q_SLASH, Q_ENT, Q_DONE
    } t_scan;

    typedef enum logic [3:0] {
        C_END, C_QUOT, C_LT, C_GT, C_EQ, C_SL, C_OTH, C_WS, C_AMP, C_SEMI
    } t_cls;

    typedef enum logic {
        B_RUN, B_STREAM
    } t_back;

    typedef struct packed {
        logic [15:0] act;
        logic [7:0]  ch;
    } t_cmd;

    localparam logic [3:0] NEXT_TAB [NUM_STATES][NUM_CLASSES] = '{
        '{Q_DONE, Q_TEXT,  Q_OPEN,  Q_INIT,  Q_INIT,  Q_TEXT,  Q_TEXT,  Q_INIT,  Q_ENT,   Q_TEXT},
        '{Q_DONE, Q_QUOTE, Q_OPEN2, Q_NAME2, Q_NAME2, Q_OPEN2, Q_NAME,  Q_OPEN2, Q_OPEN2, Q_NAME},
        '{Q_DONE, Q_QUOTE, Q_OPEN,  Q_INIT,  Q_OPEN2, Q_SLASH, Q_NAME,  Q_OPEN,  Q_OPEN,  Q_NAME},
        '{Q_DONE, Q_QUOTE, Q_INIT,  Q_INIT,  Q_NAME2, Q_NAME2, Q_NAME2, Q_OPEN,  Q_NAME,  Q_NAME},
        '{Q_DONE, Q_QUOTE, Q_OPEN,  Q_INIT,  Q_OPEN2, Q_SLASH, Q_NAME2, Q_NAME2, Q_NAME2, Q_NAME2},
        '{Q_DONE, Q_OPEN2, Q_QUOTE, Q_QUOTE, Q_QUOTE, Q_QUOTE, Q_QUOTE, Q_QUOTE, Q_QUOTE, Q_QUOTE},
        '{Q_DONE, Q_TEXT,  Q_OPEN,  Q_INIT,  Q_TEXT,  Q_TEXT,  Q_TEXT,  Q_TEXTW, Q_ENT,   Q_TEXT},
        '{Q_DONE, Q_TEXT,  Q_OPEN,  Q_INIT,  Q_TEXT,  Q_TEXT,  Q_TEXT,  Q_TEXTW, Q_ENT,   Q_TEXTW},
        '{Q_DONE, Q_QUOTE, Q_OPEN,  Q_INIT,  Q_TEXT,  Q_SLASH, Q_TEXT,  Q_SLASH, Q_ENT,   Q_SLASH},
        '{Q_DONE, Q_ENT,   Q_OPEN,  Q_INIT,  Q_ENT,   Q_ENT,   Q_ENT,   Q_ENT,   Q_ENT,   Q_TEXT},
        '{Q_DONE, Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE,  Q_DONE}
    };

    localparam logic [15:0] ACT_TAB [NUM_STATES][NUM_CLASSES] = '{
        '{F_EOF, 16'h0, 16'h0, F_GT, F_AP, F_AP, F_AP, 16'h0, 16'h0, F_AP},
        '{F_EOF, 16'h0, F_LT, F_LT | F_BK, F_GT | F_BK, F_LTS, F_LT | F_BK, 16'h0, 16'h0,
          F_AP},
        '{F_EOF, 16'h0, 16'h0, F_GT, F_EQ, F_ER1, F_AP, 16'h0, 16'h0, F_AP},
        '{F_EOF, F_WD, F_WD, F_WD | F_BK, F_WD | F_BK, F_WD, F_AP, F_WD, 16'h0, F_AP},
        '{F_EOF, 16'h0, F_WD | F_BK, F_WD | F_BK, F_WD | F_BK, F_WD | F_BK, F_AP, F_WD,
          16'h0, F_AP},
        '{F_EOF, F_QST, F_AP, F_AP, F_AP, F_AP, F_AP, F_AP, 16'h0, F_AP},
        '{F_EOF, F_AP, F_STR, F_STR, F_AP, F_AP, F_AP, F_SVW, 16'h0, F_AP},
        '{F_EOF, F_APPW, F_STR, F_SVW | F_STR | F_BK, F_APPW, F_APPW, F_APPW, 16'h0,
          F_APW, F_APPW},
        '{F_EOF, F_ER1, F_ER1, F_SGT, F_ER1, F_ER1, F_ER1, 16'h0, F_ER1, F_ER1},
        '{F_EOF, F_SVE, F_SVE, F_SVE, F_SVE, F_SVE, F_SVE, 16'h0, F_SVE, F_ESC},
        '{F_EOF, F_EOF, F_EOF, F_EOF, F_EOF, F_EOF, F_EOF, F_EOF, F_EOF, F_EOF}
    };

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        case (c)
            8'h22:   cls = C_QUOT;
            8'h3c:   cls = C_LT;
            8'h3e:   cls = C_GT;
            8'h3d:   cls = C_EQ;
            8'h2f:   cls = C_SL;
            8'h3b:   cls = C_SEMI;
            8'h26:   cls = C_AMP;
            8'h20, 8'h09, 8'h0a, 8'h0d, 8'h0c: cls = C_WS;
            default: cls = C_OTH;
        endcase
        return cls;
    endfunction

    function automatic t_scan next_of(input t_scan st, input t_cls cls);
        return t_scan'(NEXT_TAB[st][cls]);
    endfunction

    function automatic logic [15:0] action_of(input t_scan st, input t_cls cls);
        return ACT_TAB[st][cls];
    endfunction

endpackage

`default_nettype wire

// File: design/xts_front.sv
// ============================================================================
// xts_front
// Classifies input words and walks the scanner table, one pass per cycle
// while the queue has room, queueing masks beyond back-up for the back end.
// ============================================================================
`default_nettype none

module xts_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_input,
    output logic               o_push,
    output xts_pkg::t_cmd      o_cmd,
    input  wire logic          i_full
);
    import xts_pkg::*;

    t_scan       r_state, n_state;
    t_cls        r_cls;
    logic        r_pend;
    logic [7:0]  r_ch;
    logic [1:0]  r_pass;
    logic        step;
    logic        accept;
    logic [15:0] act;

    assign o_stall = r_pend;
    assign accept  = i_valid && !r_pend;
    assign step    = r_pend && !i_full;
    assign act     = action_of(r_state, r_cls);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_push   = 1'b0;
        o_cmd.act = act;
        o_cmd.ch  = r_ch;
        if (step) begin
            n_state = next_of(r_state, r_cls);
            // passes with nothing to do beyond back-up stay out of the queue
            o_push  = (act & ~F_BK) != 16'h0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_pass <= 2'd0;
        end else if (accept) begin
            r_pend <= 1'b1;
            r_pass <= 2'd0;
        end else if (step) begin
            if (((act & F_BK) != 16'h0) && (r_pass != 2'(MAX_PASS - 1))) begin
                r_pass <= r_pass + 2'd1;
            end else begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ch  <= i_in_byte;
            r_cls <= i_end_of_input ? C_END : classify(i_in_byte);
        end
    end

endmodule

`default_nettype wire

// File: design/xts_cmd_fifo.sv
// ============================================================================
// xts_cmd_fifo
// Short command queue that decouples the table walker from the executor.
// ============================================================================
`default_nettype none

module xts_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire xts_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output xts_pkg::t_cmd      o_cmd,
    output logic               o_empty
);
    import xts_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full  = r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from empty queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// File: design/xts_back.sv
// ============================================================================
// xts_back
// Executes queued action masks: token and escape buffers, entity lookup,
// fixed token emission and streaming of content tokens through the output
// register.
// ============================================================================
`default_nettype none

module xts_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire xts_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [3:0]         o_token_kind,
    output logic [7:0]         o_token_char,
    output logic               o_char_valid,
    output logic               o_token_last,
    output logic               o_bad_escape,
    output logic               o_truncated
);
    import xts_pkg::*;

    t_back              r_bstate, n_bstate;
    logic [15:0]        r_act, n_act;
    logic [7:0]         r_ch, n_ch;

    logic [7:0]         r_tok_mem [TOKEN_CAP];
    logic [7:0]         r_rd_data;
    logic [TOK_LW-1:0]  r_tok_len;
    logic               r_tok_over;
    logic [7:0]         r_esc_buf [ESCAPE_CAP];
    logic [ESC_LW-1:0]  r_esc_len;
    logic               r_esc_over;
    logic [7:0]         r_space, n_space;

    logic [TOK_LW-1:0]  r_rd_idx, n_rd_idx;
    logic [TOK_LW-1:0]  r_em_idx, n_em_idx;
    logic               r_rdv, n_rdv;
    t_kind              r_kind, n_kind;
    logic               r_lower, n_lower;

    logic               r_out_vld;
    t_kind              r_out_kind;
    logic [7:0]         r_out_char;
    logic               r_out_cv;
    logic               r_out_last;
    logic               r_out_bad;
    logic               r_out_trunc;

    logic [15:0]        rem;
    logic [15:0]        done_bit;
    logic [15:0]        fix_bit;
    logic               fix_req;
    t_kind              fix_kind;
    logic               fix_bad;
    logic               out_free;
    logic               out_load;
    t_kind              ld_kind;
    logic [7:0]         ld_char;
    logic               ld_cv;
    logic               ld_last;
    logic               ld_bad;
    logic               ld_trunc;
    logic               clr_buf;
    logic               app_en;
    logic [7:0]         app_data;
    logic               tok_room;
    logic               esc_en;
    logic               esc_clr;
    logic               rd_en;
    logic               em_last;
    logic [7:0]         low_char;
    logic               start_stream;

    logic               esc_amp, esc_lt, esc_gt, esc_quot, esc_apos;
    logic [7:0]         esc_char;

    assign o_valid      = r_out_vld;
    assign o_token_kind = r_out_kind;
    assign o_token_char = r_out_char;
    assign o_char_valid = r_out_cv;
    assign o_token_last = r_out_last;
    assign o_bad_escape = r_out_bad;
    assign o_truncated  = r_out_trunc;

    assign out_free = !r_out_vld || !i_stall;
    assign rem      = r_act & ~F_BK;
    assign tok_room = r_tok_len < TOK_LW'(TOKEN_CAP);
    assign em_last  = r_em_idx == TOK_LW'(r_tok_len - 1'b1);

    // ascii upper case folds down for word tokens
    assign low_char = (r_lower && r_rd_data >= 8'h41 && r_rd_data <= 8'h5a)
                    ? r_rd_data + 8'h20 : r_rd_data;

    // entity names: amp, lt, gt, quot, apos
    always_comb begin
        esc_amp  = !r_esc_over && r_esc_len == ESC_LW'(3) && r_esc_buf[0] == 8'h61
                && r_esc_buf[1] == 8'h6d && r_esc_buf[2] == 8'h70;
        esc_lt   = !r_esc_over && r_esc_len == ESC_LW'(2) && r_esc_buf[0] == 8'h6c
                && r_esc_buf[1] == 8'h74;
        esc_gt   = !r_esc_over && r_esc_len == ESC_LW'(2) && r_esc_buf[0] == 8'h67
                && r_esc_buf[1] == 8'h74;
        esc_quot = !r_esc_over && r_esc_len == ESC_LW'(4) && r_esc_buf[0] == 8'h71
                && r_esc_buf[1] == 8'h75 && r_esc_buf[2] == 8'h6f && r_esc_buf[3] == 8'h74;
        esc_apos = !r_esc_over && r_esc_len == ESC_LW'(4) && r_esc_buf[0] == 8'h61
                && r_esc_buf[1] == 8'h70 && r_esc_buf[2] == 8'h6f && r_esc_buf[3] == 8'h73;
        if (esc_amp) begin
            esc_char = 8'h26;
        end else if (esc_lt) begin
            esc_char = 8'h3c;
        end else if (esc_gt) begin
            esc_char = 8'h3e;
        end else if (esc_quot) begin
            esc_char = 8'h22;
        end else if (esc_apos) begin
            esc_char = 8'h27;
        end else begin
            esc_char = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_RUN;
        end else begin
            r_bstate <= n_bstate;
        end
    end

    always_comb begin
        n_bstate     = r_bstate;
        n_act        = r_act;
        n_ch         = r_ch;
        n_space      = r_space;
        n_rd_idx     = r_rd_idx;
        n_em_idx     = r_em_idx;
        n_rdv        = r_rdv;
        n_kind       = r_kind;
        n_lower      = r_lower;
        o_pop        = 1'b0;
        done_bit     = 16'h0;
        fix_bit      = 16'h0;
        fix_req      = 1'b0;
        fix_kind     = K_EOF;
        fix_bad      = 1'b0;
        out_load     = 1'b0;
        ld_kind      = K_EOF;
        ld_char      = 8'h00;
        ld_cv        = 1'b0;
        ld_last      = 1'b1;
        ld_bad       = 1'b0;
        ld_trunc     = 1'b0;
        clr_buf      = 1'b0;
        app_en       = 1'b0;
        app_data     = r_ch;
        esc_en       = 1'b0;
        esc_clr      = 1'b0;
        rd_en        = 1'b0;
        start_stream = 1'b0;

        case (r_bstate)
            B_RUN: begin
                if (rem == 16'h0) begin
                    if (!i_empty) begin
                        o_pop = 1'b1;
                        n_act = i_cmd.act;
                        n_ch  = i_cmd.ch;
                    end
                end else begin
                    // one action per cycle, in the scanner's order; a fixed token waits while the output is stalled
                    if ((rem & F_EOF) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_EOF; fix_bit = F_EOF;
                    end else if ((rem & F_LT) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_LT; fix_bit = F_LT;
                    end else if ((rem & F_LTS) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_LTS; fix_bit = F_LTS;
                    end else if ((rem & F_GT) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_GT; fix_bit = F_GT;
                    end else if ((rem & F_SGT) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_SGT; fix_bit = F_SGT;
                    end else if ((rem & F_EQ) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_EQ; fix_bit = F_EQ;
                    end else if ((rem & F_APW) != 16'h0) begin
                        app_en = 1'b1; app_data = r_space; done_bit = F_APW;
                    end else if ((rem & F_AP) != 16'h0) begin
                        app_en = 1'b1; app_data = r_ch; done_bit = F_AP;
                    end else if ((rem & F_SVW) != 16'h0) begin
                        n_space = r_ch; done_bit = F_SVW;
                    end else if ((rem & F_STR) != 16'h0) begin
                        start_stream = 1'b1; n_kind = K_TEXT; n_lower = 1'b0;
                        done_bit = F_STR;
                    end else if ((rem & F_QST) != 16'h0) begin
                        start_stream = 1'b1; n_kind = K_QUOTED; n_lower = 1'b0;
                        done_bit = F_QST;
                    end else if ((rem & F_WD) != 16'h0) begin
                        start_stream = 1'b1; n_kind = K_WORD; n_lower = 1'b1;
                        done_bit = F_WD;
                    end else if ((rem & F_ER1) != 16'h0) begin
                        fix_req = 1'b1; fix_kind = K_BAD; fix_bit = F_ER1;
                    end else if ((rem & F_SVE) != 16'h0) begin
                        esc_en = 1'b1; done_bit = F_SVE;
                    end else if ((rem & F_ESC) != 16'h0) begin
                        if (esc_char != 8'h00) begin
                            app_en   = 1'b1;
                            app_data = esc_char;
                            esc_clr  = 1'b1;
                            done_bit = F_ESC;
                        end else begin
                            fix_req = 1'b1; fix_kind = K_BAD; fix_bad = 1'b1;
                            fix_bit = F_ESC;
                        end
                    end

                    if (fix_req && out_free) begin
                        out_load = 1'b1;
                        ld_kind  = fix_kind;
                        ld_bad   = fix_bad;
                        clr_buf  = 1'b1;
                        done_bit = fix_bit;
                    end

                    n_act = r_act & ~done_bit;
                    if (start_stream) begin
                        n_bstate = B_STREAM;
                        n_rd_idx = '0;
                        n_em_idx = '0;
                        n_rdv    = 1'b0;
                    end else if (((rem & ~done_bit) == 16'h0) && !i_empty) begin
                        o_pop = 1'b1;
                        n_act = i_cmd.act;
                        n_ch  = i_cmd.ch;
                    end
                end
            end

            B_STREAM: begin
                if (r_tok_len == '0) begin
                    if (out_free) begin
                        out_load = 1'b1;
                        ld_kind  = r_kind;
                        ld_trunc = r_tok_over;
                        clr_buf  = 1'b1;
                        n_bstate = B_RUN;
                    end
                end else begin
                    // read one ahead so a character leaves every cycle the output is not stalled
                    rd_en = (r_rd_idx < r_tok_len) && (!r_rdv || out_free);
                    if (rd_en) begin
                        n_rd_idx = r_rd_idx + 1'b1;
                    end
                    if (r_rdv && out_free) begin
                        out_load = 1'b1;
                        ld_kind  = r_kind;
                        ld_char  = low_char;
                        ld_cv    = 1'b1;
                        ld_last  = em_last;
                        ld_trunc = r_tok_over;
                        n_em_idx = r_em_idx + 1'b1;
                        if (em_last) begin
                            clr_buf  = 1'b1;
                            n_bstate = B_RUN;
                        end
                    end
                    n_rdv = rd_en ? 1'b1 : (out_load ? 1'b0 : r_rdv);
                end
            end

            default: begin
                n_bstate = B_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 16'h0;
            r_space    <= 8'h00;
            r_tok_len  <= '0;
            r_tok_over <= 1'b0;
            r_esc_len  <= '0;
            r_esc_over <= 1'b0;
            r_rdv      <= 1'b0;
            r_rd_idx   <= '0;
            r_em_idx   <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_act    <= n_act;
            r_space  <= n_space;
            r_rdv    <= n_rdv;
            r_rd_idx <= n_rd_idx;
            r_em_idx <= n_em_idx;
            if (clr_buf) begin
                r_tok_len  <= '0;
                r_tok_over <= 1'b0;
                r_esc_len  <= '0;
                r_esc_over <= 1'b0;
            end else begin
                if (app_en) begin
                    if (tok_room) begin
                        r_tok_len <= r_tok_len + 1'b1;
                    end else begin
                        r_tok_over <= 1'b1;
                    end
                end
                if (esc_clr) begin
                    r_esc_len  <= '0;
                    r_esc_over <= 1'b0;
                end else if (esc_en) begin
                    if (r_esc_len < ESC_LW'(ESCAPE_CAP)) begin
                        r_esc_len <= r_esc_len + 1'b1;
                    end else begin
                        r_esc_over <= 1'b1;
                    end
                end
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_kind  <= n_kind;
        r_lower <= n_lower;
        if (out_load) begin
            r_out_kind  <= ld_kind;
            r_out_char  <= ld_char;
            r_out_cv    <= ld_cv;
            r_out_last  <= ld_last;
            r_out_bad   <= ld_bad;
            r_out_trunc <= ld_trunc;
        end
        if (esc_en && !clr_buf && !esc_clr && r_esc_len < ESC_LW'(ESCAPE_CAP)) begin
            r_esc_buf[r_esc_len[ESC_AW-1:0]] <= r_ch;
        end
    end

    // token buffer ram
    always_ff @(posedge i_clk) begin
        if (app_en && !clr_buf && tok_room) begin
            r_tok_mem[r_tok_len[TOK_AW-1:0]] <= app_data;
        end
        if (rd_en) begin
            r_rd_data <= r_tok_mem[r_rd_idx[TOK_AW-1:0]];
        end
    end

    a_tok_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tok_len <= TOK_LW'(TOKEN_CAP))
        else $error("token length beyond capacity");

    a_esc_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc_len <= ESC_LW'(ESCAPE_CAP))
        else $error("escape length beyond capacity");

    a_read_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == B_STREAM && r_rdv) |-> (r_em_idx < r_rd_idx))
        else $error("stream read index behind emit index");

    a_stream_len_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bstate == B_STREAM && $past(r_bstate) == B_STREAM) |-> $stable(r_tok_len))
        else $error("token buffer changed while streaming");

endmodule

`default_nettype wire

// File: design/xml_token_scanner.sv
// ============================================================================
// xml_token_scanner
// Table-driven XML lexer: bytes in, tokens out one character per word.
// ============================================================================
// The input side registers one byte (or end mark), then walks its table
// passes while the command queue has room, up to three passes when the
// scanner backs up; o_stall holds off the next byte until the last pass.
// Each pass that does anything goes into a four-entry command queue; the
// executor carries out the mask's actions one by one, fetching the next
// command in the cycle of the last action when the queue holds one and in
// a cycle of its own when it had run dry or has just finished a content
// token. A fixed token waits while the output word is stalled. A content
// token starts with a read lead-in from the token buffer ram and then sends
// one character per cycle while the output is not stalled. Fixed tokens and
// each content character are one output word; an empty content token is one
// word with char_valid low. No clearing pass is needed after reset.
`default_nettype none

module xml_token_scanner (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_input,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [3:0]         o_token_kind,
    output logic [7:0]         o_token_char,
    output logic               o_char_valid,
    output logic               o_token_last,
    output logic               o_bad_escape,
    output logic               o_truncated
);
    import xts_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_cmd  cmd_in;
    t_cmd  cmd_out;

    xts_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_cmd          (cmd_in),
        .i_full         (full)
    );

    xts_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_empty (empty)
    );

    xts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_out),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_token_kind (o_token_kind),
        .o_token_char (o_token_char),
        .o_char_valid (o_char_valid),
        .o_token_last (o_token_last),
        .o_bad_escape (o_bad_escape),
        .o_truncated  (o_truncated)
    );

endmodule

`default_nettype wire
